// ===== rtl/core/nes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_pkg
// Shared constants and types for the nearest enemy select block.
// ----------------------------------------------------------------------------
package nes_pkg;

  localparam int COORD_BITS     = 16;
  localparam int HP_BITS        = 16;
  localparam int TEAM_BITS      = 4;
  localparam int MAX_UNITS      = 256;
  localparam int INDEX_BITS     = $clog2(MAX_UNITS);
  localparam int DIST_BITS      = 2 * COORD_BITS + 1;
  localparam int SQ_BITS        = 2 * COORD_BITS;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_BITS = 2;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ATTACKER_X     = 2'd0,
    CFG_ATTACKER_Y     = 2'd1,
    CFG_ATTACKER_TEAM  = 2'd2,
    CFG_ATTACKER_ALIVE = 2'd3
  } cfg_reg_t;

  // One classified unit, as handed from the front to the back.
  typedef struct packed {
    logic                         eligible;
    logic                         alive;     // attacker alive flag at accept time
    logic                         last;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic [HP_BITS-1:0]           hp;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [INDEX_BITS-1:0]        index;
  } nes_item_t;

endpackage

// ===== rtl/core/nearest_enemy_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_enemy_select
// Running nearest-eligible-unit selection over a stream of unit records.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Carries
// cfg_      in         valid / ready      attacker register index and data
// in_       in         valid / stall      one unit record per item
// out_      out        valid / stall      found flag and target index
//
// One unit per cycle while in_stall is low. After the last unit of a scan
// is accepted, it passes through the front stage and the queue, and the back
// compare loads the result into the output register, which raises out_valid.
// The back squares both differences and does the ordering compare
// combinationally. Synchronous reset clears all control state and the attacker
// registers. Output stall backs up into a 4-entry queue, then the front.
// ----------------------------------------------------------------------------
module nearest_enemy_select (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nes_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [nes_pkg::COORD_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_unit_present,
  input  logic                                  in_unit_is_attacker,
  input  logic                                  in_unit_alive,
  input  logic [nes_pkg::TEAM_BITS-1:0]         in_unit_team,
  input  logic signed [nes_pkg::COORD_BITS-1:0] in_unit_x,
  input  logic signed [nes_pkg::COORD_BITS-1:0] in_unit_y,
  input  logic [nes_pkg::HP_BITS-1:0]           in_unit_hp,
  input  logic [nes_pkg::INDEX_BITS-1:0]        in_unit_index,
  input  logic                                  in_last_unit,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_target_found,
  output logic [nes_pkg::INDEX_BITS-1:0]        out_target_index
);
  import nes_pkg::*;

  logic      push;
  logic      pop;
  logic      queue_full;
  logic      queue_empty;
  nes_item_t push_item;
  nes_item_t pop_item;

  nes_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_unit_present     (in_unit_present),
    .in_unit_is_attacker (in_unit_is_attacker),
    .in_unit_alive       (in_unit_alive),
    .in_unit_team        (in_unit_team),
    .in_unit_x           (in_unit_x),
    .in_unit_y           (in_unit_y),
    .in_unit_hp          (in_unit_hp),
    .in_unit_index       (in_unit_index),
    .in_last_unit        (in_last_unit),
    .push                (push),
    .push_item           (push_item),
    .queue_full          (queue_full)
  );

  nes_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (queue_empty)
  );

  nes_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .pop_item         (pop_item),
    .empty            (queue_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_target_found (out_target_found),
    .out_target_index (out_target_index)
  );

endmodule

// ===== rtl/core/nes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_front
// Holds the attacker registers, accepts units, checks eligibility and forms
// the absolute coordinate differences.
// ----------------------------------------------------------------------------
module nes_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nes_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [nes_pkg::COORD_BITS-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_unit_present,
  input  logic                                  in_unit_is_attacker,
  input  logic                                  in_unit_alive,
  input  logic [nes_pkg::TEAM_BITS-1:0]         in_unit_team,
  input  logic signed [nes_pkg::COORD_BITS-1:0] in_unit_x,
  input  logic signed [nes_pkg::COORD_BITS-1:0] in_unit_y,
  input  logic [nes_pkg::HP_BITS-1:0]           in_unit_hp,
  input  logic [nes_pkg::INDEX_BITS-1:0]        in_unit_index,
  input  logic                                  in_last_unit,
  output logic                                  push,
  output nes_pkg::nes_item_t                    push_item,
  input  logic                                  queue_full
);
  import nes_pkg::*;

  logic signed [COORD_BITS-1:0] ax_r;
  logic signed [COORD_BITS-1:0] ay_r;
  logic [TEAM_BITS-1:0]         team_r;
  logic                         alive_r;

  logic                         stage_valid_r;
  logic                         stage_valid_nxt;
  nes_item_t                    stage_r;
  nes_item_t                    stage_nxt;

  logic signed [COORD_BITS:0]   diff_x;
  logic signed [COORD_BITS:0]   diff_y;
  logic                         advance;
  logic                         accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r    <= '0;
      ay_r    <= '0;
      team_r  <= '0;
      alive_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ATTACKER_X:     ax_r    <= cfg_data;
        CFG_ATTACKER_Y:     ay_r    <= cfg_data;
        CFG_ATTACKER_TEAM:  team_r  <= cfg_data[TEAM_BITS-1:0];
        CFG_ATTACKER_ALIVE: alive_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage moves on when it is empty or its item goes into the queue.
  assign advance  = !stage_valid_r || !queue_full;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign push     = stage_valid_r && !queue_full;

  always_comb begin
    diff_x = {in_unit_x[COORD_BITS-1], in_unit_x} - {ax_r[COORD_BITS-1], ax_r};
    diff_y = {in_unit_y[COORD_BITS-1], in_unit_y} - {ay_r[COORD_BITS-1], ay_r};
    stage_nxt.eligible = alive_r && in_unit_present && !in_unit_is_attacker
                         && in_unit_alive && (in_unit_team != team_r);
    stage_nxt.alive    = alive_r;
    stage_nxt.last     = in_last_unit;
    stage_nxt.dx       = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    stage_nxt.dy       = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    stage_nxt.hp       = in_unit_hp;
    stage_nxt.x        = in_unit_x;
    stage_nxt.y        = in_unit_y;
    stage_nxt.index    = in_unit_index;
    stage_valid_nxt    = advance ? in_valid : stage_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= stage_nxt;
    end
  end

  assign push_item = stage_r;

endmodule

// ===== rtl/core/nes_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module nes_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nes_pkg::nes_item_t push_item,
  output logic               full,
  input  logic               pop,
  output nes_pkg::nes_item_t pop_item,
  output logic               empty
);
  import nes_pkg::*;

  nes_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_r;
  logic [QPTR_BITS-1:0]  wr_ptr_nxt;
  logic [QPTR_BITS-1:0]  rd_ptr_r;
  logic [QPTR_BITS-1:0]  rd_ptr_nxt;
  logic [QPTR_BITS:0]    count_r;
  logic [QPTR_BITS:0]    count_nxt;

  assign full     = (count_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/core/nes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nes_back
// Squares the distances, keeps the running best and reports on last unit.
// ----------------------------------------------------------------------------
module nes_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nes_pkg::nes_item_t             pop_item,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_target_found,
  output logic [nes_pkg::INDEX_BITS-1:0] out_target_index
);
  import nes_pkg::*;

  logic                         best_valid_r;
  logic                         best_valid_nxt;
  logic [DIST_BITS-1:0]         best_dist_r;
  logic [DIST_BITS-1:0]         best_dist_nxt;
  logic [HP_BITS-1:0]           best_hp_r;
  logic [HP_BITS-1:0]           best_hp_nxt;
  logic signed [COORD_BITS-1:0] best_x_r;
  logic signed [COORD_BITS-1:0] best_x_nxt;
  logic signed [COORD_BITS-1:0] best_y_r;
  logic signed [COORD_BITS-1:0] best_y_nxt;
  logic [INDEX_BITS-1:0]        best_index_r;
  logic [INDEX_BITS-1:0]        best_index_nxt;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         out_found_r;
  logic                         out_found_nxt;
  logic [INDEX_BITS-1:0]        out_index_r;
  logic [INDEX_BITS-1:0]        out_index_nxt;

  logic [SQ_BITS-1:0]           sq_x;
  logic [SQ_BITS-1:0]           sq_y;
  logic [DIST_BITS-1:0]         sq_dist;
  logic                         better;
  logic                         take;
  logic                         report;

  // Output register frees up in the same cycle it is taken.
  assign pop    = !empty && (!out_valid_r || !out_stall);
  assign report = pop && pop_item.last;

  always_comb begin
    sq_x = SQ_BITS'(pop_item.dx) * SQ_BITS'(pop_item.dx);
    sq_y = SQ_BITS'(pop_item.dy) * SQ_BITS'(pop_item.dy);
    sq_dist = {1'b0, sq_x} + {1'b0, sq_y};
    // Lexicographic order: distance, then hp, then x, then y.
    if (!best_valid_r) begin
      better = 1'b1;
    end else if (sq_dist != best_dist_r) begin
      better = sq_dist < best_dist_r;
    end else if (pop_item.hp != best_hp_r) begin
      better = pop_item.hp > best_hp_r;
    end else if (pop_item.x != best_x_r) begin
      better = pop_item.x < best_x_r;
    end else begin
      better = pop_item.y > best_y_r;
    end
    take = pop && pop_item.eligible && better;
  end

  always_comb begin
    best_valid_nxt = best_valid_r;
    best_dist_nxt  = best_dist_r;
    best_hp_nxt    = best_hp_r;
    best_x_nxt     = best_x_r;
    best_y_nxt     = best_y_r;
    best_index_nxt = best_index_r;
    if (take) begin
      best_valid_nxt = 1'b1;
      best_dist_nxt  = sq_dist;
      best_hp_nxt    = pop_item.hp;
      best_x_nxt     = pop_item.x;
      best_y_nxt     = pop_item.y;
      best_index_nxt = pop_item.index;
    end

    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    if (report) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = best_valid_nxt && pop_item.alive;
      out_index_nxt = (best_valid_nxt && pop_item.alive) ? best_index_nxt : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      best_valid_r <= report ? 1'b0 : best_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // A cleared best is only ever compared after best_valid_r is set again.
  always_ff @(posedge clk) begin
    best_dist_r  <= best_dist_nxt;
    best_hp_r    <= best_hp_nxt;
    best_x_r     <= best_x_nxt;
    best_y_r     <= best_y_nxt;
    best_index_r <= best_index_nxt;
    out_found_r  <= out_found_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_target_found = out_found_r;
  assign out_target_index = out_index_r;

  a_none_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_index_r == '0))
    else $error("no target but nonzero index");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    report |=> !best_valid_r)
    else $error("kept best not cleared after last unit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=>
      (out_valid_r && $stable(out_found_r) && $stable(out_index_r)))
    else $error("stalled result changed");

endmodule

// ===== dv/tb_nearest_enemy_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_enemy_select
// Streams unit records through nearest_enemy_select and checks each reported
// target against an in-bench predictor that keeps its own copy of the
// attacker registers and the running best. Directed scans cover eligibility
// rules, every tie-break key, coordinate extremes, a dead attacker and a
// register change in the middle of a scan. Random scans follow under several
// attacker settings, with random valid gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_nearest_enemy_select;
  import nes_pkg::*;

  typedef struct packed {
    logic                  present;
    logic                  is_attacker;
    logic                  alive;
    logic [TEAM_BITS-1:0]  team;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [HP_BITS-1:0]    hp;
    logic [INDEX_BITS-1:0] index;
    logic                  last;
  } unit_rec_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] index;
  } target_rec_t;

  class target_scoreboard;
    logic signed [COORD_BITS-1:0] atk_x;
    logic signed [COORD_BITS-1:0] atk_y;
    logic [TEAM_BITS-1:0]         atk_team;
    logic                         atk_alive;

    bit                    have_best;
    longint unsigned       best_dist;
    logic [HP_BITS-1:0]    best_hp;
    int                    best_x;
    int                    best_y;
    logic [INDEX_BITS-1:0] best_index;

    target_rec_t targets_due[$];
    int mismatches;
    int units_seen;
    int results_seen;
    int found_seen;

    function new();
      atk_x = '0;
      atk_y = '0;
      atk_team = '0;
      atk_alive = 1'b0;
      mismatches = 0;
      units_seen = 0;
      results_seen = 0;
      found_seen = 0;
      clear_best();
    endfunction

    function void clear_best();
      have_best = 1'b0;
      best_dist = 0;
      best_hp = '0;
      best_x = 0;
      best_y = 0;
      best_index = '0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [COORD_BITS-1:0] d);
      case (r)
        CFG_ATTACKER_X:     atk_x = d;
        CFG_ATTACKER_Y:     atk_y = d;
        CFG_ATTACKER_TEAM:  atk_team = d[TEAM_BITS-1:0];
        CFG_ATTACKER_ALIVE: atk_alive = d[0];
        default: ;
      endcase
    endfunction

    function void note_unit(unit_rec_t u);
      longint          dx;
      longint          dy;
      longint unsigned unit_dist;
      bit              wins;
      int              ux;
      int              uy;
      target_rec_t     t;
      units_seen++;
      ux = int'($signed(u.x));
      uy = int'($signed(u.y));
      if (atk_alive && u.present && !u.is_attacker && u.alive && u.team != atk_team) begin
        dx = longint'(ux) - longint'(atk_x);
        dy = longint'(uy) - longint'(atk_y);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        unit_dist = longint'(dx * dx + dy * dy);
        // order: distance, then hp (higher), x (smaller), y (larger)
        if (!have_best) wins = 1'b1;
        else if (unit_dist != best_dist) wins = unit_dist < best_dist;
        else if (u.hp != best_hp) wins = u.hp > best_hp;
        else if (ux != best_x) wins = ux < best_x;
        else wins = uy > best_y;
        if (wins) begin
          have_best = 1'b1;
          best_dist = unit_dist;
          best_hp = u.hp;
          best_x = ux;
          best_y = uy;
          best_index = u.index;
        end
      end
      if (u.last) begin
        t.found = have_best && atk_alive;
        t.index = t.found ? best_index : '0;
        targets_due.push_back(t);
        clear_best();
      end
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_target(logic found, logic [INDEX_BITS-1:0] index);
      target_rec_t want;
      if (targets_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%b index=%0d", found, index));
        return;
      end
      want = targets_due.pop_front();
      results_seen++;
      if (want.found) found_seen++;
      if (found !== want.found)
        report_mismatch($sformatf("target_found %b, want %b", found, want.found));
      if (index !== want.index)
        report_mismatch($sformatf("target_index %0d, want %0d", index, want.index));
    endtask

    task close_out();
      if (targets_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", targets_due.size()));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index = CFG_ATTACKER_X;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_unit_present = 1'b0;
  logic                  in_unit_is_attacker = 1'b0;
  logic                  in_unit_alive = 1'b0;
  logic [TEAM_BITS-1:0]  in_unit_team = '0;
  logic [COORD_BITS-1:0] in_unit_x = '0;
  logic [COORD_BITS-1:0] in_unit_y = '0;
  logic [HP_BITS-1:0]    in_unit_hp = '0;
  logic [INDEX_BITS-1:0] in_unit_index = '0;
  logic                  in_last_unit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_target_found;
  logic [INDEX_BITS-1:0] out_target_index;

  target_scoreboard sb;
  int idle_pct = 0;

  nearest_enemy_select i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_unit_present     (in_unit_present),
    .in_unit_is_attacker (in_unit_is_attacker),
    .in_unit_alive       (in_unit_alive),
    .in_unit_team        (in_unit_team),
    .in_unit_x           (in_unit_x),
    .in_unit_y           (in_unit_y),
    .in_unit_hp          (in_unit_hp),
    .in_unit_index       (in_unit_index),
    .in_last_unit        (in_last_unit),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_target_found    (out_target_found),
    .out_target_index    (out_target_index)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: check accepted results, stall in random bursts
  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0)
        sb.check_target(out_target_found, out_target_index);
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 8);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic unit_rec_t unit_at(bit present, bit is_atk, bit alive, int team,
                                        int x, int y, int hp, int index, bit last);
    unit_rec_t u;
    u.present = present;
    u.is_attacker = is_atk;
    u.alive = alive;
    u.team = TEAM_BITS'(team);
    u.x = COORD_BITS'(x);
    u.y = COORD_BITS'(y);
    u.hp = HP_BITS'(hp);
    u.index = INDEX_BITS'(index);
    u.last = last;
    return u;
  endfunction

  // coordinate near the attacker (tight ties), mid range, or anywhere
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [COORD_BITS-1:0] base);
    case ($urandom_range(2))
      0: return COORD_BITS'(base + $urandom_range(6) - 3);
      1: return COORD_BITS'(base + $urandom_range(600) - 300);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic unit_rec_t random_unit(bit last);
    unit_rec_t   u;
    int unsigned hp_set[4] = '{0, 1, 7, 65535};
    u.present = $urandom_range(9) != 0;
    u.is_attacker = $urandom_range(19) == 0;
    u.alive = $urandom_range(7) != 0;
    u.team = ($urandom_range(3) == 0) ? sb.atk_team : TEAM_BITS'($urandom);
    u.x = pick_coord(sb.atk_x);
    u.y = pick_coord(sb.atk_y);
    u.hp = $urandom_range(1) ? HP_BITS'($urandom) : HP_BITS'(hp_set[$urandom_range(3)]);
    u.index = INDEX_BITS'($urandom);
    u.last = last;
    return u;
  endfunction

  task automatic send_unit(unit_rec_t u);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_unit_present <= u.present;
    in_unit_is_attacker <= u.is_attacker;
    in_unit_alive <= u.alive;
    in_unit_team <= u.team;
    in_unit_x <= u.x;
    in_unit_y <= u.y;
    in_unit_hp <= u.hp;
    in_unit_index <= u.index;
    in_last_unit <= u.last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_unit(u);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [COORD_BITS-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(r, d);
  endtask

  // drain first: a non-last unit may still sit in the pipe after the last result
  task automatic set_attacker(int x, int y, int team, bit alive);
    in_valid <= 1'b0;
    while (sb.targets_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(CFG_ATTACKER_X, COORD_BITS'(x));
    cfg_write(CFG_ATTACKER_Y, COORD_BITS'(y));
    cfg_write(CFG_ATTACKER_TEAM, {12'($urandom), TEAM_BITS'(team)});
    cfg_write(CFG_ATTACKER_ALIVE, {15'($urandom), alive});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int scan_len;
    int guard;
    int unsigned gap_set[3] = '{10, 25, 50};
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // attacker dead out of reset: eligible-looking units give no target
    send_unit(unit_at(1, 0, 1, 5, 10, 10, 50, 1, 0));
    send_unit(unit_at(1, 0, 1, 5, -10, 10, 50, 2, 1));

    set_attacker(100, -50, 3, 1);
    // eligibility: empty, self, dead, same team, then two enemies
    send_unit(unit_at(0, 0, 1, 5, 100, -50, 9, 40, 0));
    send_unit(unit_at(1, 1, 1, 5, 100, -50, 9, 41, 0));
    send_unit(unit_at(1, 0, 0, 5, 100, -50, 9, 42, 0));
    send_unit(unit_at(1, 0, 1, 3, 100, -50, 9, 43, 0));
    send_unit(unit_at(1, 0, 1, 0, 400, 300, 9, 5, 0));
    send_unit(unit_at(1, 0, 1, 15, 110, -40, 9, 9, 0));
    send_unit(unit_at(0, 0, 0, 3, 0, 0, 0, 44, 1));
    // distance tie broken on hp
    send_unit(unit_at(1, 0, 1, 5, 103, -50, 10, 1, 0));
    send_unit(unit_at(1, 0, 1, 5, 97, -50, 20, 2, 0));
    send_unit(unit_at(1, 0, 1, 5, 100, -53, 65535, 3, 1));
    // distance and hp tie: y, then x, then y again, then a full tie keeps the first
    send_unit(unit_at(1, 0, 1, 5, 103, -54, 5, 10, 0));
    send_unit(unit_at(1, 0, 1, 5, 103, -46, 5, 11, 0));
    send_unit(unit_at(1, 0, 1, 5, 96, -53, 5, 12, 0));
    send_unit(unit_at(1, 0, 1, 5, 96, -47, 5, 13, 0));
    send_unit(unit_at(1, 0, 1, 5, 96, -47, 5, 14, 1));
    // best kept across a register change keeps its old distance
    send_unit(unit_at(1, 0, 1, 0, 100, -50, 0, 20, 0));
    set_attacker(-32768, -32768, 15, 1);
    send_unit(unit_at(1, 0, 1, 0, 32767, 32767, 0, 255, 0));
    send_unit(unit_at(1, 0, 1, 14, 32767, -32768, 0, 0, 1));
    send_unit(unit_at(1, 0, 1, 14, 32767, -32768, 65535, 0, 1));
    send_unit(unit_at(1, 0, 1, 0, 32767, 32767, 0, 255, 1));

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_attacker(32767, 32767, 0, 1);
        2: set_attacker(int'($urandom), int'($urandom), $urandom_range(15), 1'b0);
        3: set_attacker(-32768, 32767, 15, 1);
        default: set_attacker(int'($urandom), int'($urandom), $urandom_range(15), 1'b1);
      endcase
      idle_pct = (ph == 1 || ph >= 6) ? 0 : int'(gap_set[$urandom_range(2)]);
      sent = 0;
      while (sent < 150) begin
        if ($urandom_range(9) == 0) begin
          // noise: anything goes, including stray scan ends
          send_unit(unit_rec_t'({$urandom, $urandom}));
          sent++;
        end else begin
          scan_len = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
          for (int k = 0; k < scan_len; k++) send_unit(random_unit(k == scan_len - 1));
          sent += scan_len;
        end
      end
    end

    in_valid <= 1'b0;
    guard = 0;
    while (sb.targets_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    sb.close_out();

    $display("Ran %0d unit records under 11 attacker settings, incl. dead attacker and extremes",
             sb.units_seen);
    $display("Checked %0d scan results, %0d with a target chosen",
             sb.results_seen, sb.found_seen);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nes_pkg.sv
rtl/core/nes_front.sv
rtl/core/nes_queue.sv
rtl/core/nes_back.sv
rtl/core/nearest_enemy_select.sv
dv/tb_nearest_enemy_select.sv
